@@ rtl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

	localparam int HUE_W             = 24;
	localparam int UNIT_W            = 16;
	localparam int SV_W              = UNIT_W + 1;
	localparam int CH_W              = 8;
	// 255 * 1.0 in UNIT_W fraction bits fits in 24 bits
	localparam int VSC_W             = 24;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [SV_W-1:0] UNIT_ONE = SV_W'(1) << UNIT_W;

	// hue sectors, in order of the color wheel
	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

endpackage

@@ rtl/hsv2rgb_in_if.sv @@
interface hsv2rgb_in_if;

	logic                                      valid;
	logic                                      ready;
	logic signed [hsv2rgb_pkg::HUE_W-1:0]      hue;
	logic        [hsv2rgb_pkg::SV_W-1:0]       saturation;
	logic        [hsv2rgb_pkg::SV_W-1:0]       brightness_value;

	modport source (output valid, hue, saturation, brightness_value, input ready);
	modport sink   (input valid, hue, saturation, brightness_value, output ready);

endinterface

@@ rtl/hsv2rgb_out_if.sv @@
interface hsv2rgb_out_if;

	logic                            valid;
	logic                            ready;
	logic [hsv2rgb_pkg::CH_W-1:0]    red;
	logic [hsv2rgb_pkg::CH_W-1:0]    green;
	logic [hsv2rgb_pkg::CH_W-1:0]    blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink   (input valid, red, green, blue, output ready);

endinterface

@@ rtl/hsv_to_rgb_pixel_converter_top.sv @@
// HSV to 8-bit RGB converter. Hue is a signed turn count with FRACTION_BITS
// fraction bits of which only the fraction is used; saturation and value run
// 0..65536 (1.0) and are clamped above that. A pixel goes in every clock
// unless back-pressure holds it; its color passes the stages clamp and
// sector, coefficient products, subtract from one, channel products, sum
// and truncate, sector select. Each stage holds its own valid bit and stalls
// only when the stage after it is full; bubbles close up under back-pressure.
module hsv_to_rgb_pixel_converter_top #(
	parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	hsv2rgb_in_if.sink    hsv,
	hsv2rgb_out_if.source rgb
);
	import hsv2rgb_pkg::*;

	localparam int KW = FRACTION_BITS + SV_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en1, en2, en3, en4, en5, en6;

	sector_t           sec_s1;
	logic [FRACTION_BITS-1:0] frac_s1;
	logic [SV_W-1:0]   sat_s1;
	logic [VSC_W-1:0]  vsc_s1;

	sector_t           sec_s3;
	logic [VSC_W-1:0]  vsc_s3;
	logic [KW-1:0]     mp_s3;
	logic [KW-1:0]     mq_s3;
	logic [KW-1:0]     mt_s3;

	sector_t           sec_s4, sec_s5;
	logic [CH_W-1:0]   bv_s4, bv_s5;
	logic [CH_W-1:0]   p_s5, q_s5, t_s5;
	logic [CH_W-1:0]   red_s6, green_s6, blue_s6;
	logic [CH_W-1:0]   red_c, green_c, blue_c;

	// a stage loads when it is empty or its contents move on
	assign en6 = !vld_s6 || rgb.ready;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign hsv.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= hsv.valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
		end
	end

	hsv2rgb_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
		.clk              (clk),
		.en               (en1),
		.hue              (hsv.hue),
		.saturation       (hsv.saturation),
		.brightness_value (hsv.brightness_value),
		.sec_s1           (sec_s1),
		.frac_s1          (frac_s1),
		.sat_s1           (sat_s1),
		.vsc_s1           (vsc_s1)
	);

	hsv2rgb_coef #(.FRACTION_BITS(FRACTION_BITS)) u_coef (
		.clk     (clk),
		.en2     (en2),
		.en3     (en3),
		.sec_s1  (sec_s1),
		.frac_s1 (frac_s1),
		.sat_s1  (sat_s1),
		.vsc_s1  (vsc_s1),
		.sec_s3  (sec_s3),
		.vsc_s3  (vsc_s3),
		.mp_s3   (mp_s3),
		.mq_s3   (mq_s3),
		.mt_s3   (mt_s3)
	);

	hsv2rgb_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan_p (
		.clk    (clk),
		.en4    (en4),
		.en5    (en5),
		.vsc_s3 (vsc_s3),
		.m_s3   (mp_s3),
		.ch_s5  (p_s5)
	);

	hsv2rgb_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan_q (
		.clk    (clk),
		.en4    (en4),
		.en5    (en5),
		.vsc_s3 (vsc_s3),
		.m_s3   (mq_s3),
		.ch_s5  (q_s5)
	);

	hsv2rgb_chan #(.FRACTION_BITS(FRACTION_BITS)) u_chan_t (
		.clk    (clk),
		.en4    (en4),
		.en5    (en5),
		.vsc_s3 (vsc_s3),
		.m_s3   (mt_s3),
		.ch_s5  (t_s5)
	);

	always_ff @(posedge clk) begin
		if (en4) begin
			sec_s4 <= sec_s3;
			bv_s4  <= vsc_s3[VSC_W-1 -: CH_W];
		end
		if (en5) begin
			sec_s5 <= sec_s4;
			bv_s5  <= bv_s4;
		end
	end

	always_comb begin
		case (sec_s5)
			SEC_YELLOW: begin
				red_c = q_s5;  green_c = bv_s5; blue_c = p_s5;
			end
			SEC_GREEN: begin
				red_c = p_s5;  green_c = bv_s5; blue_c = t_s5;
			end
			SEC_CYAN: begin
				red_c = p_s5;  green_c = q_s5;  blue_c = bv_s5;
			end
			SEC_BLUE: begin
				red_c = t_s5;  green_c = p_s5;  blue_c = bv_s5;
			end
			SEC_MAGENTA: begin
				red_c = bv_s5; green_c = p_s5;  blue_c = q_s5;
			end
			default: begin
				red_c = bv_s5; green_c = t_s5;  blue_c = p_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en6) begin
			red_s6   <= red_c;
			green_s6 <= green_c;
			blue_s6  <= blue_c;
		end
	end

	assign rgb.valid = vld_s6;
	assign rgb.red   = red_s6;
	assign rgb.green = green_s6;
	assign rgb.blue  = blue_s6;

endmodule

@@ rtl/hsv2rgb_prep.sv @@
module hsv2rgb_prep #(
	parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [hsv2rgb_pkg::HUE_W-1:0]      hue,
	input  logic [hsv2rgb_pkg::SV_W-1:0]       saturation,
	input  logic [hsv2rgb_pkg::SV_W-1:0]       brightness_value,
	output hsv2rgb_pkg::sector_t               sec_s1,
	output logic [FRACTION_BITS-1:0]           frac_s1,
	output logic [hsv2rgb_pkg::SV_W-1:0]       sat_s1,
	output logic [hsv2rgb_pkg::VSC_W-1:0]      vsc_s1
);
	import hsv2rgb_pkg::*;

	localparam int H6_W = FRACTION_BITS + 3;

	logic [H6_W-1:0]  hfrac;
	logic [H6_W-1:0]  h6;
	logic [SV_W-1:0]  sat_c;
	logic [SV_W-1:0]  val_c;
	logic [VSC_W-1:0] vsc_c;

	always_comb begin
		// whole turns drop out, negative hues wrap for free
		hfrac = H6_W'(hue[FRACTION_BITS-1:0]);
		h6    = (hfrac << 2) + (hfrac << 1);
		sat_c = (saturation > UNIT_ONE) ? UNIT_ONE : saturation;
		val_c = (brightness_value > UNIT_ONE) ? UNIT_ONE : brightness_value;
		// v * 255 as v * 256 - v; wraps mod 2^24 but the result fits
		vsc_c = VSC_W'({val_c, 8'd0}) - VSC_W'(val_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sec_s1  <= sector_t'(h6[H6_W-1:FRACTION_BITS]);
			frac_s1 <= h6[FRACTION_BITS-1:0];
			sat_s1  <= sat_c;
			vsc_s1  <= vsc_c;
		end
	end

endmodule

@@ rtl/hsv2rgb_coef.sv @@
module hsv2rgb_coef #(
	parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
	input  logic                                                  clk,
	input  logic                                                  en2,
	input  logic                                                  en3,
	input  hsv2rgb_pkg::sector_t                                  sec_s1,
	input  logic [FRACTION_BITS-1:0]                              frac_s1,
	input  logic [hsv2rgb_pkg::SV_W-1:0]                          sat_s1,
	input  logic [hsv2rgb_pkg::VSC_W-1:0]                         vsc_s1,
	output hsv2rgb_pkg::sector_t                                  sec_s3,
	output logic [hsv2rgb_pkg::VSC_W-1:0]                         vsc_s3,
	output logic [FRACTION_BITS+hsv2rgb_pkg::SV_W-1:0]            mp_s3,
	output logic [FRACTION_BITS+hsv2rgb_pkg::SV_W-1:0]            mq_s3,
	output logic [FRACTION_BITS+hsv2rgb_pkg::SV_W-1:0]            mt_s3
);
	import hsv2rgb_pkg::*;

	localparam int KW = FRACTION_BITS + SV_W;
	localparam logic [KW-1:0] WHOLE = KW'(1) << (FRACTION_BITS + UNIT_W);

	logic [FRACTION_BITS:0] fcomp;
	logic [KW:0]            kt_full;
	logic [KW-1:0]          kq_c;

	sector_t           sec_s2;
	logic [VSC_W-1:0]  vsc_s2;
	logic [KW-1:0]     kp_s2;
	logic [KW-1:0]     kq_s2;
	logic [KW-1:0]     kt_s2;

	always_comb begin
		fcomp   = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
		fcomp   = fcomp - (FRACTION_BITS+1)'(frac_s1);
		kq_c    = frac_s1 * sat_s1;
		kt_full = fcomp * sat_s1;
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			sec_s2 <= sec_s1;
			vsc_s2 <= vsc_s1;
			kp_s2  <= {sat_s1, {FRACTION_BITS{1'b0}}};
			kq_s2  <= kq_c;
			// at most 2^(F+16), so the top bit is always clear
			kt_s2  <= kt_full[KW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			sec_s3 <= sec_s2;
			vsc_s3 <= vsc_s2;
			mp_s3  <= WHOLE - kp_s2;
			mq_s3  <= WHOLE - kq_s2;
			mt_s3  <= WHOLE - kt_s2;
		end
	end

endmodule

@@ rtl/hsv2rgb_chan.sv @@
module hsv2rgb_chan #(
	parameter int FRACTION_BITS = hsv2rgb_pkg::FRACTION_BITS_DEF
) (
	input  logic                                           clk,
	input  logic                                           en4,
	input  logic                                           en5,
	input  logic [hsv2rgb_pkg::VSC_W-1:0]                  vsc_s3,
	input  logic [FRACTION_BITS+hsv2rgb_pkg::SV_W-1:0]     m_s3,
	output logic [hsv2rgb_pkg::CH_W-1:0]                   ch_s5
);
	import hsv2rgb_pkg::*;

	localparam int KW   = FRACTION_BITS + SV_W;
	localparam int PH_W = VSC_W + FRACTION_BITS + 1;
	localparam int PL_W = VSC_W + UNIT_W;

	logic [PH_W-1:0] ph_s4;
	logic [PL_W-1:0] pl_s4;
	logic [PH_W-1:0] sum;

	// vsc * m split at bit 16 of m so each multiplier is at most 24 x (F+1) bits
	always_ff @(posedge clk) begin
		if (en4) begin
			ph_s4 <= vsc_s3 * m_s3[KW-1:UNIT_W];
			pl_s4 <= vsc_s3 * m_s3[UNIT_W-1:0];
		end
	end

	// floor(vsc*m / 2^(F+32)); low 16 bits of pl never carry into the result
	assign sum = ph_s4 + PH_W'(pl_s4 >> UNIT_W);

	always_ff @(posedge clk) begin
		if (en5) begin
			ch_s5 <= sum[FRACTION_BITS+UNIT_W +: CH_W];
		end
	end

endmodule

@@ tb/tb_hsv_to_rgb_pixel_converter_top.sv @@
module tb_hsv_to_rgb_pixel_converter_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hsv2rgb_pkg::*;

	localparam int FB          = FRACTION_BITS_DEF;
	localparam int RAND_PIXELS = 1650;
	localparam int IDLE_LIMIT  = 3000;
	localparam int DRAIN_WAIT  = 16;
	localparam int LONG_STALL  = 300;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} color_t;

	typedef struct {
		logic [HUE_W-1:0] hue;
		logic [SV_W-1:0]  sat;
		logic [SV_W-1:0]  val;
		bit               known;
		color_t           color;
	} pixel_row_t;

	localparam int N_ROWS = 22;

	// known = 1: color typed in; otherwise the predictor decides
	pixel_row_t pixel_rows [N_ROWS] = '{
		'{24'h000000, 17'd0,      17'd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
		'{24'h000000, 17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{24'h000000, 17'd0,      17'd65536,  1'b1, '{8'd255, 8'd255, 8'd255}},
		'{24'h008000, 17'd65536,  17'd65536,  1'b1, '{8'd0,   8'd255, 8'd255}},
		'{24'hFF8000, 17'd65536,  17'd65536,  1'b1, '{8'd0,   8'd255, 8'd255}},
		'{24'hFF0000, 17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{24'h7FFFFF, 17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{24'h800000, 17'd65536,  17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{24'h000000, 17'd131071, 17'd65536,  1'b1, '{8'd255, 8'd0,   8'd0}},
		'{24'h000000, 17'd0,      17'd131071, 1'b1, '{8'd255, 8'd255, 8'd255}},
		'{24'h000000, 17'd65536,  17'd131071, 1'b1, '{8'd255, 8'd0,   8'd0}},
		'{24'hFFC000, 17'd65536,  17'd65536,  1'b1, '{8'd127, 8'd0,   8'd255}},
		'{24'h001555, 17'd40000,  17'd50000,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h004000, 17'd40000,  17'd50000,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h006AAB, 17'd40000,  17'd50000,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h009555, 17'd40000,  17'd50000,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h00C000, 17'd40000,  17'd50000,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h00EAAB, 17'd40000,  17'd50000,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h00FFFF, 17'd65535,  17'd1,      1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h002AAB, 17'd65536,  17'd65535,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h002AAA, 17'd65536,  17'd65535,  1'b0, '{8'd0,   8'd0,   8'd0}},
		'{24'h555555, 17'd32768,  17'd65535,  1'b0, '{8'd0,   8'd0,   8'd0}}
	};

	logic clk;
	logic arst_n;

	hsv2rgb_in_if  pix_in ();
	hsv2rgb_out_if pix_out ();

	hsv_to_rgb_pixel_converter_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.hsv    (pix_in),
		.rgb    (pix_out)
	);

	// typed-in color travels with the payload so the checker sees it on the same beat
	bit     drive_known;
	color_t drive_color;

	color_t pending_colors [$];
	int     mismatches;
	int     colors_seen;
	bit     calm;
	bit     long_stall_done;
	int     idle_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor(vsc * (2^(F+16) - k) / 2^(F+32))
	function automatic logic [CH_W-1:0] scaled_term(logic [63:0] vsc, logic [63:0] k);
		logic [63:0] prod;
		prod = vsc * ((64'd1 << (FB + UNIT_W)) - k);
		return CH_W'(prod >> (FB + 2 * UNIT_W));
	endfunction

	function automatic color_t expected_color(logic [HUE_W-1:0] hue, logic [SV_W-1:0] sat,
			logic [SV_W-1:0] val);
		logic [63:0] fmask, h6, fnum, s, v, vsc;
		logic [CH_W-1:0] bv, p, q, t;
		sector_t sec;
		color_t c;
		fmask = (64'd1 << FB) - 64'd1;
		s     = (sat > UNIT_ONE) ? 64'(UNIT_ONE) : 64'(sat);
		v     = (val > UNIT_ONE) ? 64'(UNIT_ONE) : 64'(val);
		// whole turns drop out, negative hues included
		h6    = (64'(hue) & fmask) * 64'd6;
		sec   = sector_t'(h6 >> FB);
		fnum  = h6 & fmask;
		vsc   = v * 64'd255;
		bv    = CH_W'(vsc >> UNIT_W);
		p     = scaled_term(vsc, s << FB);
		q     = scaled_term(vsc, fnum * s);
		t     = scaled_term(vsc, ((64'd1 << FB) - fnum) * s);
		case (sec)
			SEC_YELLOW:  c = '{q,  bv, p};
			SEC_GREEN:   c = '{p,  bv, t};
			SEC_CYAN:    c = '{p,  q,  bv};
			SEC_BLUE:    c = '{t,  p,  bv};
			SEC_MAGENTA: c = '{bv, p,  q};
			default:     c = '{bv, t,  p};
		endcase
		return c;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SV_W-1:0] random_unit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		else if (r < 15)
			return UNIT_ONE;
		else if (r < 22)
			return SV_W'($urandom_range(65537, 131071));
		return SV_W'($urandom_range(0, 65536));
	endfunction

	function automatic logic [HUE_W-1:0] random_hue();
		logic [HUE_W-1:0] h;
		int sec_edge;
		h = HUE_W'($urandom());
		if ($urandom_range(0, 9) == 0) begin
			// land next to a sector boundary, any whole turn count
			sec_edge = ($urandom_range(0, 5) * (1 << FB) + 5) / 6 + $urandom_range(0, 6) - 3;
			h[FB-1:0] = FB'(sec_edge);
		end
		return h;
	endfunction

	task automatic offer_pixel(logic [HUE_W-1:0] hue, logic [SV_W-1:0] sat,
			logic [SV_W-1:0] val, bit known, color_t color);
		int gap;
		gap = pick_gap();
		repeat (gap) begin
			@(negedge clk);
			pix_in.valid = 1'b0;
		end
		@(negedge clk);
		pix_in.valid            = 1'b1;
		pix_in.hue              = hue;
		pix_in.saturation       = sat;
		pix_in.brightness_value = val;
		drive_known             = known;
		drive_color             = color;
		do
			@(posedge clk);
		while (!pix_in.ready);
	endtask

	// beat accounting: results are checked before the new input beat is queued
	always @(posedge clk) begin
		color_t want, got;
		if (arst_n) begin
			if (pix_out.valid && pix_out.ready) begin
				got = '{pix_out.red, pix_out.green, pix_out.blue};
				colors_seen++;
				if (pending_colors.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat r=%0d g=%0d b=%0d",
						$time, got.r, got.g, got.b);
				end else begin
					want = pending_colors.pop_front();
					if (got.r !== want.r) begin
						mismatches++;
						$display("%0t: red expected %0d got %0d", $time, want.r, got.r);
					end
					if (got.g !== want.g) begin
						mismatches++;
						$display("%0t: green expected %0d got %0d", $time, want.g, got.g);
					end
					if (got.b !== want.b) begin
						mismatches++;
						$display("%0t: blue expected %0d got %0d", $time, want.b, got.b);
					end
				end
			end
			if (pix_in.valid && pix_in.ready)
				pending_colors.push_back(drive_known ? drive_color :
					expected_color(pix_in.hue, pix_in.saturation, pix_in.brightness_value));
			if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// output side back-pressure
	initial begin
		int stall_left;
		stall_left    = 0;
		pix_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!long_stall_done && colors_seen >= 700) begin
				long_stall_done = 1'b1;
				stall_left      = LONG_STALL;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 9) < 3) begin
				stall_left = pick_gap();
			end
			if (stall_left > 0) begin
				pix_out.ready = 1'b0;
				stall_left--;
			end else begin
				pix_out.ready = 1'b1;
			end
		end
	end

	initial begin
		logic [HUE_W-1:0] hue;
		logic [SV_W-1:0]  sat, val;
		arst_n                  = 1'b0;
		pix_in.valid            = 1'b0;
		pix_in.hue              = '0;
		pix_in.saturation       = '0;
		pix_in.brightness_value = '0;
		drive_known             = 1'b0;
		drive_color             = '0;
		mismatches              = 0;
		colors_seen             = 0;
		calm                    = 1'b0;
		long_stall_done         = 1'b0;
		idle_cycles             = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		foreach (pixel_rows[i])
			offer_pixel(pixel_rows[i].hue, pixel_rows[i].sat, pixel_rows[i].val,
				pixel_rows[i].known, pixel_rows[i].color);

		for (int n = 0; n < RAND_PIXELS; n++) begin
			calm = (n >= 400 && n < 600) || (n >= 1300 && n < 1400);
			if (n == 1000) begin
				// let the pipeline run dry before going on
				@(negedge clk);
				pix_in.valid = 1'b0;
				while (pending_colors.size() != 0)
					@(posedge clk);
			end
			hue = random_hue();
			sat = random_unit();
			val = random_unit();
			offer_pixel(hue, sat, val, 1'b0, '0);
		end
		@(negedge clk);
		pix_in.valid = 1'b0;
		calm         = 1'b0;

		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
